[rtl/lmsw_pkg.sv]
`timescale 1ns / 1ps
// lmsw_pkg: types, constants and register map of the LED matrix scan word formatter.
// Used by every module of the block; depends on nothing.
package lmsw_pkg;

    localparam int MAX_LINE_PIXELS_DEFAULT = 256;
    localparam int ROW_ADDRESS_BITS        = 4;
    localparam int QUEUE_DEPTH             = 4;

    localparam int PPL_W = 9;
    localparam int GAP_W = 6;
    localparam int LPH_W = 5;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [PPL_W-1:0] PIXELS_PER_LINE_RESET = 9'd64;
    localparam logic [GAP_W-1:0] GAP_CYCLES_RESET      = 6'd40;
    localparam logic [LPH_W-1:0] LINES_PER_HALF_RESET  = 5'd16;

    typedef enum logic [1:0] {
        REG_PIXELS_PER_LINE = 2'd0,
        REG_GAP_CYCLES      = 2'd1,
        REG_LINES_PER_HALF  = 2'd2,
        REG_UNUSED          = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [4:0] upper_red;
        logic [5:0] upper_green;
        logic [4:0] upper_blue;
        logic [4:0] lower_red;
        logic [5:0] lower_green;
        logic [4:0] lower_blue;
    } pixel_pair_t;

    typedef struct packed {
        logic                        red_top;
        logic                        green_top;
        logic                        blue_top;
        logic                        red_bottom;
        logic                        green_bottom;
        logic                        blue_bottom;
        logic                        latch_strobe;
        logic                        output_off;
        logic [ROW_ADDRESS_BITS-1:0] row_address;
        logic                        run_end;
    } panel_word_t;

    typedef struct packed {
        logic [PPL_W-1:0] pixels_per_line;
        logic [GAP_W-1:0] gap_cycles;
        logic [LPH_W-1:0] lines_per_half;
    } cfg_t;

    // One classified pixel pair: color MSBs (top r,g,b then bottom r,g,b).
    typedef struct packed {
        logic [5:0]                  color;
        logic                        last;
        logic [ROW_ADDRESS_BITS-1:0] row;
        logic [GAP_W-1:0]            gap;
    } cmd_t;

endpackage

[rtl/lmsw_front.sv]
`timescale 1ns / 1ps
// lmsw_front: accepts pixel pairs, tracks column and line, builds queue commands.
// Depends on lmsw_pkg.
module lmsw_front #(
    parameter int MAX_LINE_PIXELS = lmsw_pkg::MAX_LINE_PIXELS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lmsw_pkg::cfg_t       cfg,
    input  logic                 push,
    input  lmsw_pkg::pixel_pair_t pixel,
    input  logic                 queue_full,
    output logic                 queue_push,
    output lmsw_pkg::cmd_t       queue_cmd
);

    localparam int CW   = $clog2(MAX_LINE_PIXELS);
    localparam int PW0  = $clog2(MAX_LINE_PIXELS + 1);
    localparam int PW   = (PW0 > lmsw_pkg::PPL_W) ? PW0 : lmsw_pkg::PPL_W;
    localparam int RAB  = lmsw_pkg::ROW_ADDRESS_BITS;
    localparam int LHW  = (RAB + 1 > lmsw_pkg::LPH_W) ? RAB + 1 : lmsw_pkg::LPH_W;
    localparam logic [PW-1:0]  PPL_MAX = PW'(MAX_LINE_PIXELS);
    localparam logic [LHW-1:0] LPH_MAX = LHW'(1) << RAB;

    logic [CW-1:0]  column_reg, column_next;
    logic [RAB-1:0] line_reg, line_next;
    logic [PW-1:0]  ppl_ext, ppl_eff;
    logic [LHW-1:0] lph_ext, lph_eff;
    logic           last;
    logic           line_wrap;
    logic           accept;

    always_comb
    begin
        ppl_ext = PW'(cfg.pixels_per_line);
        if (ppl_ext == '0)
            ppl_eff = PW'(1);
        else if (ppl_ext > PPL_MAX)
            ppl_eff = PPL_MAX;
        else
            ppl_eff = ppl_ext;

        lph_ext = LHW'(cfg.lines_per_half);
        if (lph_ext == '0)
            lph_eff = LHW'(1);
        else if (lph_ext > LPH_MAX)
            lph_eff = LPH_MAX;
        else
            lph_eff = lph_ext;
    end

    assign last      = PW'(column_reg) >= (ppl_eff - PW'(1));
    assign line_wrap = (LHW'(line_reg) + LHW'(1)) >= lph_eff;
    assign accept    = push && !queue_full;

    assign queue_push      = accept;
    assign queue_cmd.color = {pixel.upper_red[4], pixel.upper_green[5], pixel.upper_blue[4],
                              pixel.lower_red[4], pixel.lower_green[5], pixel.lower_blue[4]};
    assign queue_cmd.last  = last;
    assign queue_cmd.row   = line_reg;
    assign queue_cmd.gap   = cfg.gap_cycles;

    always_comb
    begin
        column_next = column_reg;
        line_next   = line_reg;
        if (accept)
        begin
            if (last)
            begin
                column_next = '0;
                line_next   = line_wrap ? '0 : line_reg + RAB'(1);
            end
            else
            begin
                column_next = column_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            line_reg   <= '0;
        end
        else
        begin
            column_reg <= column_next;
            line_reg   <= line_next;
        end
    end

endmodule

[rtl/lmsw_cmd_fifo.sv]
`timescale 1ns / 1ps
// lmsw_cmd_fifo: short command queue between front and back.
// Depends on lmsw_pkg.
module lmsw_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lmsw_pkg::cmd_t cmd_in,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output lmsw_pkg::cmd_t cmd_out
);

    localparam int DEPTH = lmsw_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    lmsw_pkg::cmd_t mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = count_reg == NW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign cmd_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + NW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/lmsw_back.sv]
`timescale 1ns / 1ps
// lmsw_back: expands queued commands into panel words (pixel word, gap run at line end).
// Depends on lmsw_pkg.
module lmsw_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  lmsw_pkg::cmd_t        head,
    output logic                  head_pop,
    output logic                  empty,
    input  logic                  pop,
    output lmsw_pkg::panel_word_t word
);

    localparam int GW = lmsw_pkg::GAP_W;

    logic                  in_gap_reg, in_gap_next;
    logic [GW-1:0]         gap_idx_reg, gap_idx_next;
    logic                  out_valid_reg, out_valid_next;
    lmsw_pkg::panel_word_t word_reg;
    lmsw_pkg::panel_word_t word_new;
    logic                  advance, emit, finish;

    assign advance = !out_valid_reg || pop;
    assign emit    = head_valid && advance;

    always_comb
    begin
        word_new             = '0;
        word_new.row_address = head.row;
        if (!in_gap_reg)
        begin
            {word_new.red_top, word_new.green_top, word_new.blue_top,
             word_new.red_bottom, word_new.green_bottom, word_new.blue_bottom} = head.color;
            word_new.latch_strobe = head.last;
            word_new.output_off   = 1'b1;
            finish                = !head.last || (head.gap == '0);
        end
        else
        begin
            word_new.output_off = gap_idx_reg > (head.gap >> 1);
            finish              = gap_idx_reg == (head.gap - GW'(1));
        end
        word_new.run_end = finish;
    end

    assign head_pop = emit && finish;

    always_comb
    begin
        in_gap_next    = in_gap_reg;
        gap_idx_next   = gap_idx_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (finish)
            begin
                in_gap_next  = 1'b0;
                gap_idx_next = '0;
            end
            else
            begin
                in_gap_next  = 1'b1;
                gap_idx_next = in_gap_reg ? gap_idx_reg + GW'(1) : '0;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_gap_reg    <= 1'b0;
            gap_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_gap_reg    <= in_gap_next;
            gap_idx_reg   <= gap_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            word_reg <= word_new;
    end

    assign empty = !out_valid_reg;
    assign word  = word_reg;

endmodule

[rtl/led_matrix_scan_word_formatter_core.sv]
`timescale 1ns / 1ps
// led_matrix_scan_word_formatter_core: top level, APB registers, front, queue, back.
// Depends on lmsw_pkg, lmsw_front, lmsw_cmd_fifo, lmsw_back.
//
// channel   direction  handshake               payload
// pixel     in         push / full             lmsw_pkg::pixel_pair_t
// word      out        empty / pop             lmsw_pkg::panel_word_t
// apb       in/out     psel penable pwrite     paddr, pwdata, prdata (pready tied high)
//
// One pixel request per cycle while the line runs and the queue has room; a line's
// last pair yields 1 + gap_cycles words, one per cycle from the back end while popped.
// The 4-entry command queue lets the front take pixels during a gap run
// until it fills. Output word is registered; pop and refill share a cycle.
// Reset: asynchronous, active low; registers return to 64 / 40 / 16.
module led_matrix_scan_word_formatter_core #(
    parameter int MAX_LINE_PIXELS = lmsw_pkg::MAX_LINE_PIXELS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  lmsw_pkg::pixel_pair_t               pixel,
    output logic                                empty,
    input  logic                                pop,
    output lmsw_pkg::panel_word_t               word,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lmsw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lmsw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lmsw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int DW = lmsw_pkg::APB_DATA_W;

    lmsw_pkg::cfg_t     cfg_reg, cfg_next;
    lmsw_pkg::reg_index_t reg_sel;
    logic               wr_en;
    logic               q_push, q_full, q_pop, q_empty;
    lmsw_pkg::cmd_t     q_in, q_out;

    assign pready  = 1'b1;
    assign reg_sel = lmsw_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                lmsw_pkg::REG_PIXELS_PER_LINE:
                    cfg_next.pixels_per_line = pwdata[lmsw_pkg::PPL_W-1:0];
                lmsw_pkg::REG_GAP_CYCLES:
                    cfg_next.gap_cycles = pwdata[lmsw_pkg::GAP_W-1:0];
                lmsw_pkg::REG_LINES_PER_HALF:
                    cfg_next.lines_per_half = pwdata[lmsw_pkg::LPH_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            lmsw_pkg::REG_PIXELS_PER_LINE: prdata = DW'(cfg_reg.pixels_per_line);
            lmsw_pkg::REG_GAP_CYCLES:      prdata = DW'(cfg_reg.gap_cycles);
            lmsw_pkg::REG_LINES_PER_HALF:  prdata = DW'(cfg_reg.lines_per_half);
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixels_per_line <= lmsw_pkg::PIXELS_PER_LINE_RESET;
            cfg_reg.gap_cycles      <= lmsw_pkg::GAP_CYCLES_RESET;
            cfg_reg.lines_per_half  <= lmsw_pkg::LINES_PER_HALF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign full = q_full;

    lmsw_front #(
        .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .pixel      (pixel),
        .queue_full (q_full),
        .queue_push (q_push),
        .queue_cmd  (q_in)
    );

    lmsw_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .cmd_out (q_out)
    );

    lmsw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_empty),
        .head       (q_out),
        .head_pop   (q_pop),
        .empty      (empty),
        .pop        (pop),
        .word       (word)
    );

endmodule

[rtl/lmsw_checker.sv]
`timescale 1ns / 1ps
// lmsw_checker: port-level assertions for the scan word formatter, bound to the top.
// Depends on lmsw_pkg and led_matrix_scan_word_formatter_core.
module lmsw_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            push,
    input logic                            full,
    input lmsw_pkg::pixel_pair_t           pixel,
    input logic                            empty,
    input logic                            pop,
    input lmsw_pkg::panel_word_t           word,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [lmsw_pkg::APB_ADDR_W-1:0] paddr,
    input logic [lmsw_pkg::APB_DATA_W-1:0] pwdata,
    input logic [lmsw_pkg::APB_DATA_W-1:0] prdata,
    input logic                            pready
);

    // waiting word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(word))
        else $error("result changed while stalled");

    // a latch word is a pixel word, so output is off
    a_latch_off: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && word.latch_strobe |-> word.output_off)
        else $error("latch with output enabled");

    // enabled words are gap words: no color, no latch
    a_gap_dark: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !word.output_off |->
            !word.latch_strobe && !word.red_top && !word.green_top && !word.blue_top &&
            !word.red_bottom && !word.green_bottom && !word.blue_bottom)
        else $error("color in enabled gap word");

    // a non-latching pixel word ends its run
    a_pixel_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && word.output_off && !word.latch_strobe &&
        (word.red_top || word.green_top || word.blue_top ||
         word.red_bottom || word.green_bottom || word.blue_bottom) |-> word.run_end)
        else $error("pixel word without run end");

endmodule

bind led_matrix_scan_word_formatter_core lmsw_checker u_lmsw_checker (.*);

[verif/lmsw_word_tracker_pkg.sv]
`timescale 1ns / 1ps
// lmsw_word_tracker_pkg: expected panel words for the scan word formatter bench.
// Depends on lmsw_pkg for the request, word and register types.
package lmsw_word_tracker_pkg;

    import lmsw_pkg::*;

    class panel_word_tracker;

        logic [PPL_W-1:0] line_len;
        logic [GAP_W-1:0] gap_len;
        logic [LPH_W-1:0] frame_lines;
        int unsigned      column;
        int unsigned      line;
        panel_word_t      due_words[$];
        int unsigned      faults;
        int unsigned      words_seen;
        int unsigned      pairs_taken;
        int unsigned      latches_due;

        function new();
            line_len    = PIXELS_PER_LINE_RESET;
            gap_len     = GAP_CYCLES_RESET;
            frame_lines = LINES_PER_HALF_RESET;
            column      = 0;
            line        = 0;
            faults      = 0;
            words_seen  = 0;
            pairs_taken = 0;
            latches_due = 0;
        endfunction

        function void report(string what);
            faults++;
            if (faults <= 10)
                $display("mismatch: %s", what);
        endfunction

        function string fmt_word(panel_word_t w);
            return $sformatf("rgb top %b%b%b bot %b%b%b latch %b off %b row %0d end %b",
                w.red_top, w.green_top, w.blue_top, w.red_bottom, w.green_bottom,
                w.blue_bottom, w.latch_strobe, w.output_off, w.row_address, w.run_end);
        endfunction

        function void apply_reg(reg_index_t idx, logic [31:0] bus_value);
            case (idx)
                REG_PIXELS_PER_LINE: line_len    = bus_value[PPL_W-1:0];
                REG_GAP_CYCLES:      gap_len     = bus_value[GAP_W-1:0];
                REG_LINES_PER_HALF:  frame_lines = bus_value[LPH_W-1:0];
                default: ;
            endcase
        endfunction

        function void compare_reg(reg_index_t idx, logic [31:0] got);
            logic [31:0] want;
            want = '0;
            case (idx)
                REG_PIXELS_PER_LINE: want[PPL_W-1:0] = line_len;
                REG_GAP_CYCLES:      want[GAP_W-1:0] = gap_len;
                REG_LINES_PER_HALF:  want[LPH_W-1:0] = frame_lines;
                default: return;
            endcase
            if (got !== want)
                report($sformatf("register %s read %h, expected %h", idx.name(), got, want));
        endfunction

        function void take_pixel_pair(pixel_pair_t px);
            int unsigned len;
            int unsigned lines;
            int unsigned gap;
            int unsigned i;
            logic        last;
            panel_word_t w;
            logic [ROW_ADDRESS_BITS-1:0] row;

            len = line_len;
            if (len == 0) len = 1;
            if (len > MAX_LINE_PIXELS_DEFAULT) len = MAX_LINE_PIXELS_DEFAULT;
            lines = frame_lines;
            if (lines == 0) lines = 1;
            if (lines > (1 << ROW_ADDRESS_BITS)) lines = 1 << ROW_ADDRESS_BITS;
            gap  = gap_len;
            row  = line[ROW_ADDRESS_BITS-1:0];
            last = (column >= len - 1);
            pairs_taken++;

            w              = '0;
            w.red_top      = px.upper_red[4];
            w.green_top    = px.upper_green[5];
            w.blue_top     = px.upper_blue[4];
            w.red_bottom   = px.lower_red[4];
            w.green_bottom = px.lower_green[5];
            w.blue_bottom  = px.lower_blue[4];
            w.latch_strobe = last;
            w.output_off   = 1'b1;
            w.row_address  = row;
            w.run_end      = !last || (gap == 0);
            due_words.push_back(w);

            if (!last)
            begin
                column++;
                return;
            end

            latches_due++;
            for (i = 0; i < gap; i++)
            begin
                w             = '0;
                w.output_off  = (i > gap / 2);
                w.row_address = row;
                w.run_end     = (i + 1 == gap);
                due_words.push_back(w);
            end
            column = 0;
            line   = (line + 1 >= lines) ? 0 : line + 1;
        endfunction

        function void match_panel_word(panel_word_t got);
            panel_word_t want;
            words_seen++;
            if (due_words.size() == 0)
            begin
                report({"word with nothing due: ", fmt_word(got)});
                return;
            end
            want = due_words.pop_front();
            if (got.red_top !== want.red_top || got.green_top !== want.green_top ||
                got.blue_top !== want.blue_top || got.red_bottom !== want.red_bottom ||
                got.green_bottom !== want.green_bottom ||
                got.blue_bottom !== want.blue_bottom ||
                got.latch_strobe !== want.latch_strobe ||
                got.output_off !== want.output_off ||
                got.row_address !== want.row_address || got.run_end !== want.run_end)
                report($sformatf("word %0d expected [%s] got [%s]", words_seen,
                    fmt_word(want), fmt_word(got)));
        endfunction

    endclass

endpackage

[verif/led_matrix_scan_word_formatter_core_tb.sv]
`timescale 1ns / 1ps
// led_matrix_scan_word_formatter_core_tb: directed and random pixel-pair traffic with
// register changes between phases; every panel word is checked against the tracker.
// Depends on lmsw_pkg, lmsw_word_tracker_pkg and the formatter core.
module led_matrix_scan_word_formatter_core_tb;

    import lmsw_pkg::*;
    import lmsw_word_tracker_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    pixel_pair_t           pixel;
    logic                  empty;
    logic                  pop;
    panel_word_t           word;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    panel_word_tracker tracker;
    int unsigned       pair_gap_pct;
    int unsigned       word_stall_pct;
    int unsigned       hold_off_left;
    int unsigned       clock_ticks;
    int unsigned       settings_used;

    led_matrix_scan_word_formatter_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .pixel   (pixel),
        .empty   (empty),
        .pop     (pop),
        .word    (word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        clock_ticks = 0;
        while (clock_ticks <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            clock_ticks++;
        end
        $display("timeout after %0d cycles", clock_ticks);
        $display("[FAIL] regression broken");
        $finish;
    end

    // word side: random stalls, plus a long hold-off when requested
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                pop = 1'b0;
                hold_off_left--;
            end
            else
                pop = ($urandom_range(99) >= word_stall_pct);
            @(posedge clk);
            if (pop && !empty)
                tracker.match_panel_word(word);
        end
    end

    task automatic send_pair(input pixel_pair_t px);
        @(negedge clk);
        while ($urandom_range(99) < pair_gap_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push  = 1'b1;
        pixel = px;
        @(posedge clk);
        while (full) @(posedge clk);
        tracker.take_pixel_pair(px);
    endtask

    task automatic drain();
        @(negedge clk);
        push = 1'b0;
        while (tracker.due_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic read_reg(input reg_index_t idx);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        tracker.compare_reg(idx, prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // bits above the field carry noise; the register keeps only its own width
    task automatic program_reg(input reg_index_t idx, input int unsigned field);
        logic [31:0] bus_value;
        bus_value = $urandom;
        case (idx)
            REG_PIXELS_PER_LINE: bus_value[PPL_W-1:0] = field[PPL_W-1:0];
            REG_GAP_CYCLES:      bus_value[GAP_W-1:0] = field[GAP_W-1:0];
            REG_LINES_PER_HALF:  bus_value[LPH_W-1:0] = field[LPH_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = bus_value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        tracker.apply_reg(idx, bus_value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx != REG_UNUSED)
            read_reg(idx);
    endtask

    task automatic setup_line(input int unsigned len, input int unsigned gap,
                              input int unsigned lines);
        program_reg(REG_PIXELS_PER_LINE, len);
        program_reg(REG_GAP_CYCLES, gap);
        program_reg(REG_LINES_PER_HALF, lines);
        settings_used++;
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned k;
        int unsigned len;
        int unsigned gap;
        int unsigned lines;

        tracker        = new();
        rst_n          = 1'b0;
        push           = 1'b0;
        pixel          = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        pair_gap_pct   = 0;
        word_stall_pct = 0;
        hold_off_left  = 0;
        settings_used  = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        read_reg(REG_PIXELS_PER_LINE);
        read_reg(REG_GAP_CYCLES);
        read_reg(REG_LINES_PER_HALF);

        // every pair ends a line, no gap words, single-line frame
        setup_line(1, 0, 1);
        send_pair(pixel_pair_t'(32'h0000_0000));
        send_pair(pixel_pair_t'(32'hFFFF_FFFF));
        send_pair(pixel_pair_t'(32'h8410_8410));
        send_pair(pixel_pair_t'(32'h7BEF_7BEF));
        drain();

        // zero line length, longest gap
        setup_line(0, 63, 16);
        send_pair(pixel_pair_t'($urandom));
        drain();

        // zero line count
        setup_line(3, 2, 0);
        repeat (4) send_pair(pixel_pair_t'($urandom));
        drain();

        // line shortened under the current column
        setup_line(6, 1, 5);
        repeat (4) send_pair(pixel_pair_t'($urandom));
        drain();
        program_reg(REG_PIXELS_PER_LINE, 2);
        send_pair(pixel_pair_t'($urandom));
        drain();

        // frame shortened under the current line; unused index ignored
        setup_line(1, 1, 31);
        repeat (9) send_pair(pixel_pair_t'($urandom));
        drain();
        program_reg(REG_UNUSED, $urandom);
        read_reg(REG_PIXELS_PER_LINE);
        read_reg(REG_GAP_CYCLES);
        read_reg(REG_LINES_PER_HALF);
        program_reg(REG_LINES_PER_HALF, 3);
        repeat (2) send_pair(pixel_pair_t'($urandom));
        drain();

        for (phase = 0; phase < 8; phase++)
        begin
            len   = (phase == 4) ? 0 : $urandom_range(1, 12);
            gap   = (phase == 0) ? 0 : (phase == 1) ? 63 : $urandom_range(0, 63);
            lines = (phase == 2) ? 0 : (phase == 3) ? 31 : $urandom_range(1, 20);
            setup_line(len, gap, lines);
            case (phase % 4)
                0: begin pair_gap_pct = 0;  word_stall_pct = 0;  end
                1: begin pair_gap_pct = 52; word_stall_pct = 0;  end
                2: begin pair_gap_pct = 0;  word_stall_pct = 52; end
                default: begin pair_gap_pct = 7; word_stall_pct = 7; end
            endcase
            for (k = 0; k < 12; k++)
                send_pair(pixel_pair_t'($urandom));
            drain();
        end

        // oversize line length; receiver holds off first
        pair_gap_pct   = 0;
        word_stall_pct = 0;
        setup_line($urandom_range(257, 511), $urandom_range(0, 8), $urandom_range(1, 16));
        hold_off_left = 300;
        for (k = 0; k < 150; k++)
            send_pair(pixel_pair_t'($urandom));
        drain();
        repeat (20) @(posedge clk);

        if (tracker.due_words.size() != 0)
            tracker.report($sformatf("%0d words never arrived", tracker.due_words.size()));

        $display("pixel pairs: %0d, panel words checked: %0d, line ends: %0d",
            tracker.pairs_taken, tracker.words_seen, tracker.latches_due);
        $display("register settings: %0d, mismatches: %0d, cycles: %0d",
            settings_used, tracker.faults, clock_ticks);
        if (tracker.faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
rtl/lmsw_pkg.sv
rtl/lmsw_front.sv
rtl/lmsw_cmd_fifo.sv
rtl/lmsw_back.sv
rtl/led_matrix_scan_word_formatter_core.sv
rtl/lmsw_checker.sv
verif/lmsw_word_tracker_pkg.sv
verif/led_matrix_scan_word_formatter_core_tb.sv
